>>> hdl/periodic_budget_enforcer_macros.svh
// assertion macros for the periodic budget enforcer
// no dependencies; included by the top level only
`ifndef PERIODIC_BUDGET_ENFORCER_MACROS_SVH
`define PERIODIC_BUDGET_ENFORCER_MACROS_SVH
`ifndef ASSERT_OFF
`define PBE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");
`define PBE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define PBE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PBE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hdl/pbe_pkg.sv
// shared types and constants for the periodic budget enforcer
// no dependencies
package pbe_pkg;
   localparam int TIME_BITS = 64;
   localparam int CNT_BITS = $clog2(TIME_BITS);
   localparam int CSR_IDX_BITS = 1;
   localparam logic [TIME_BITS-1:0] BUDGET_RESET = TIME_BITS'(10000);
   localparam logic [TIME_BITS-1:0] PERIOD_RESET = TIME_BITS'(10000);
   localparam logic [CSR_IDX_BITS-1:0] CSR_BUDGET = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PERIOD = 1'b1;

   typedef enum logic [2:0] {
      OP_CHECK = 3'd0,
      OP_ACTIVATE = 3'd1,
      OP_DEACTIVATE = 3'd2,
      OP_START = 3'd3,
      OP_STOP = 3'd4
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EVAL,
      S_SCHED,
      S_DIV,
      S_STEP,
      S_ADVANCE,
      S_REARM,
      S_OUT
   } state_type;

   function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                    input logic [TIME_BITS-1:0] b);
      logic [TIME_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
   endfunction
endpackage

>>> hdl/periodic_budget_enforcer.sv
// periodic budget enforcer top level: event sequencer and bit-serial divider
// depends on pbe_pkg and periodic_budget_enforcer_macros.svh
//
// usage:
//   req channel carries one event (req_op, req_now); rsp channel returns one
//   result per event with the state after it. csr_we writes budget (index 0)
//   or period (index 1) from csr_data; write only while idle.
//   activate, deactivate, stop and time checks without replenishment pass
//   from evaluation straight to output. start, and a time check whose
//   replenishment fires, go through scheduling, rearm and output, with
//   division, step and advance before rearm when catch-up is needed: the
//   remainder of the catch-up division is found one bit per cycle by a
//   shared restoring subtractor.
//   one event is in flight at a time; req_stall is high from transfer until
//   the result is loaded into the output register.
//   the output register holds a result while rsp_stall is high; a new event
//   can be taken meanwhile and its result waits until the register frees.
//   synchronous reset restores budget and period to 10000, stored budget to
//   10000, may_run to one, and disarms deadline and replenishment.
`include "periodic_budget_enforcer_macros.svh"
module periodic_budget_enforcer import pbe_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_op,
   input  logic [TIME_BITS-1:0]    req_now,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_may_run,
   output logic [TIME_BITS-1:0]    rsp_remaining_budget,
   output logic [TIME_BITS-1:0]    rsp_next_replenish,
   output logic [TIME_BITS-1:0]    rsp_deadline,
   output logic                    rsp_reschedule,
   output logic                    rsp_wake_blocked,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [TIME_BITS-1:0]    csr_data
);
   state_type state_ff, state_in;
   logic [2:0] op_ff, op_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [TIME_BITS-1:0] budget_ff, period_ff, p_eff;
   logic [TIME_BITS-1:0] left_ff, left_in, rt_ff, rt_in, exh_ff, exh_in;
   logic run_ff, run_in, exh_armed_ff, exh_armed_in, rep_armed_ff, rep_armed_in;
   logic active_ff, active_in, resched_ff, resched_in, wake_ff, wake_in;
   logic [TIME_BITS-1:0] rem_ff, rem_in, dvd_ff, dvd_in, step_ff, step_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [TIME_BITS-1:0] rsp_left_ff, rsp_rt_ff, rsp_dl_ff;
   logic rsp_run_ff, rsp_resched_ff, rsp_wake_ff, rsp_load;
   logic [TIME_BITS:0] shifted, trial;

   assign p_eff = (period_ff == '0) ? TIME_BITS'(1) : period_ff;
   assign shifted = {rem_ff, dvd_ff[TIME_BITS-1]};
   assign trial = shifted - {1'b0, p_eff};

   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= BUDGET_RESET;
         period_ff <= PERIOD_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_BUDGET) budget_ff <= csr_data;
         if (csr_index == CSR_PERIOD) period_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         left_ff <= BUDGET_RESET;
         rt_ff <= '0;
         exh_ff <= '0;
         run_ff <= 1'b1;
         exh_armed_ff <= 1'b0;
         rep_armed_ff <= 1'b0;
         active_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         left_ff <= left_in;
         rt_ff <= rt_in;
         exh_ff <= exh_in;
         run_ff <= run_in;
         exh_armed_ff <= exh_armed_in;
         rep_armed_ff <= rep_armed_in;
         active_ff <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      now_ff <= now_in;
      resched_ff <= resched_in;
      wake_ff <= wake_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      step_ff <= step_in;
      cnt_ff <= cnt_in;
      if (rsp_load) begin
         rsp_run_ff <= run_ff;
         rsp_left_ff <= left_ff;
         rsp_rt_ff <= rt_ff;
         rsp_dl_ff <= exh_armed_ff ? exh_ff : '0;
         rsp_resched_ff <= resched_ff;
         rsp_wake_ff <= wake_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      now_in = now_ff;
      left_in = left_ff;
      rt_in = rt_ff;
      exh_in = exh_ff;
      run_in = run_ff;
      exh_armed_in = exh_armed_ff;
      rep_armed_in = rep_armed_ff;
      active_in = active_ff;
      resched_in = resched_ff;
      wake_in = wake_ff;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      step_in = step_ff;
      cnt_in = cnt_ff;
      rsp_load = 1'b0;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_op;
               now_in = req_now;
               resched_in = 1'b0;
               wake_in = 1'b0;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = S_OUT;
            case (op_ff)
               OP_CHECK: begin
                  if (exh_armed_ff && now_ff >= exh_ff) begin
                     run_in = 1'b0;
                     exh_armed_in = 1'b0;
                     resched_in = 1'b1;
                  end
                  if (rep_armed_ff && now_ff >= rt_ff) begin
                     left_in = budget_ff;
                     run_in = 1'b1;
                     wake_in = 1'b1;
                     resched_in = 1'b1;
                     state_in = S_SCHED;
                  end
               end
               OP_ACTIVATE: begin
                  active_in = 1'b1;
                  exh_in = sat_add(now_ff, left_ff);
                  exh_armed_in = 1'b1;
               end
               OP_DEACTIVATE, OP_STOP: begin
                  active_in = 1'b0;
                  left_in = (exh_ff > now_ff) ? exh_ff - now_ff : '0;
                  exh_armed_in = 1'b0;
                  if (op_ff == OP_STOP) rep_armed_in = 1'b0;
               end
               OP_START: begin
                  left_in = budget_ff;
                  run_in = 1'b1;
                  state_in = S_SCHED;
               end
               default: begin
                  state_in = S_OUT;
               end
            endcase
         end
         S_SCHED: begin
            rep_armed_in = 1'b1;
            if (now_ff >= rt_ff) begin
               rem_in = '0;
               dvd_in = now_ff - rt_ff;
               cnt_in = '0;
               state_in = S_DIV;
            end else begin
               state_in = S_REARM;
            end
         end
         S_DIV: begin
            rem_in = trial[TIME_BITS] ? shifted[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
            dvd_in = {dvd_ff[TIME_BITS-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(TIME_BITS - 1)) state_in = S_STEP;
         end
         S_STEP: begin
            // whole periods past now: (now - rt) - remainder + period
            step_in = sat_add((now_ff - rt_ff) - rem_ff, p_eff);
            state_in = S_ADVANCE;
         end
         S_ADVANCE: begin
            rt_in = sat_add(rt_ff, step_ff);
            state_in = S_REARM;
         end
         S_REARM: begin
            if (op_ff == OP_CHECK && active_ff) begin
               exh_in = sat_add(now_ff, left_ff);
               exh_armed_in = 1'b1;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_may_run = rsp_run_ff;
   assign rsp_remaining_budget = rsp_left_ff;
   assign rsp_next_replenish = rsp_rt_ff;
   assign rsp_deadline = rsp_dl_ff;
   assign rsp_reschedule = rsp_resched_ff;
   assign rsp_wake_blocked = rsp_wake_ff;

   `PBE_ASSERT_NEXT(a_accept_eval, clock, reset, req_valid && !req_stall, state_ff == S_EVAL)
   `PBE_ASSERT_IMPL(a_wake_runs, clock, reset, rsp_valid && rsp_wake_blocked,
                    rsp_reschedule && rsp_may_run)
   `PBE_ASSERT_NEXT(a_div_leaves, clock, reset,
                    state_ff == S_DIV && cnt_ff == CNT_BITS'(TIME_BITS - 1),
                    state_ff == S_STEP)
endmodule
